[rtl/core/pcx_rle_image_decoder_unit_assert.svh]
// Assertion macros for the PCX run-length image decoder.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef PCX_RLE_IMAGE_DECODER_UNIT_ASSERT_SVH
`define PCX_RLE_IMAGE_DECODER_UNIT_ASSERT_SVH

// pre implies post in the same cycle
`define PCXRLE_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("pcxrle implication check failed");

// cond never holds
`define PCXRLE_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("pcxrle forbidden condition seen");

`endif

[rtl/core/pcxrle_pkg.sv]
// Shared types and constants for the PCX run-length image decoder.
// No dependencies; used by the front, command queue, back and top level.
package pcxrle_pkg;

   localparam int CMD_FIFO_DEPTH = 4;

   localparam logic [7:0] RUN_MARK     = 8'hC0;
   localparam logic [7:0] RUN_MASK     = 8'h3F;
   localparam logic [7:0] MAKER_ID     = 8'h0A;
   localparam logic [7:0] HDR_VERSION  = 8'd5;
   localparam logic [7:0] HDR_ENCODING = 8'd1;
   localparam logic [7:0] HDR_BPP      = 8'd8;

   localparam int PAL_START = 16;
   localparam int PAL_LEN   = 48;
   localparam int FILL_LEN  = 58;

   localparam logic [6:0] HDR_POS_MAKER    = 7'd0;
   localparam logic [6:0] HDR_POS_VERSION  = 7'd1;
   localparam logic [6:0] HDR_POS_ENCODING = 7'd2;
   localparam logic [6:0] HDR_POS_BPP      = 7'd3;
   localparam logic [6:0] HDR_POS_XMAX_LO  = 7'd8;
   localparam logic [6:0] HDR_POS_XMAX_HI  = 7'd9;
   localparam logic [6:0] HDR_POS_YMAX_LO  = 7'd10;
   localparam logic [6:0] HDR_POS_YMAX_HI  = 7'd11;
   localparam logic [6:0] HDR_POS_PLANES   = 7'(PAL_START + PAL_LEN + 1);
   localparam logic [6:0] HDR_POS_BPL_LO   = 7'(PAL_START + PAL_LEN + 2);
   localparam logic [6:0] HDR_POS_BPL_HI   = 7'(PAL_START + PAL_LEN + 3);
   localparam logic [6:0] HDR_POS_LAST     = 7'(PAL_START + PAL_LEN + 1 + 5 + FILL_LEN - 1);

   localparam logic [1:0] RES_PIXEL  = 2'd0;
   localparam logic [1:0] RES_ACCEPT = 2'd1;
   localparam logic [1:0] RES_REJECT = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_REJECT
   } phase_type;

   typedef enum logic [1:0] {
      CMD_PIXELS,
      CMD_HDR_OK,
      CMD_HDR_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic [5:0]   count;
      logic [15:0]  last_col;
      logic [15:0]  last_line;
      logic [23:0]  row_len;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic done;
   } back_stat_type;

endpackage

[rtl/core/pcxrle_front.sv]
// Front end: header parser and RLE packet classifier.
// Depends on pcxrle_pkg; pushes commands into the command queue.
module pcxrle_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_start,
   output logic               in_ready,
   input  logic               q_full,
   output logic               q_push,
   output pcxrle_pkg::cmd_type q_cmd
);
   import pcxrle_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [6:0]  hpos_ff, hpos_in;
   logic        ok_ff, ok_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] lcol_ff, lcol_in;
   logic [15:0] lline_ff, lline_in;
   logic [7:0]  planes_ff, planes_in;
   logic [15:0] bpr_ff, bpr_in;
   logic        await_ff, await_in;
   logic [5:0]  pend_ff, pend_in;

   phase_type   ph;
   logic [6:0]  pos;
   logic        ok;
   logic        await;
   logic [5:0]  pend;
   logic        fire;
   logic        run_byte;
   logic        mismatch;
   logic [23:0] span;
   logic [16:0] width;

   assign in_ready = !q_full;
   assign fire     = in_valid && !q_full;
   assign run_byte = (in_byte & RUN_MARK) == RUN_MARK;

   assign ph    = in_start ? PH_HEADER : phase_ff;
   assign pos   = in_start ? 7'd0 : hpos_ff;
   assign ok    = in_start ? 1'b1 : ok_ff;
   assign await = in_start ? 1'b0 : await_ff;
   assign pend  = in_start ? 6'd0 : pend_ff;

   assign mismatch = (pos == HDR_POS_MAKER    && in_byte != MAKER_ID)     ||
                     (pos == HDR_POS_VERSION  && in_byte != HDR_VERSION)  ||
                     (pos == HDR_POS_ENCODING && in_byte != HDR_ENCODING) ||
                     (pos == HDR_POS_BPP      && in_byte != HDR_BPP);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      ok_in     = ok_ff;
      low_in    = low_ff;
      lcol_in   = lcol_ff;
      lline_in  = lline_ff;
      planes_in = planes_ff;
      bpr_in    = bpr_ff;
      await_in  = await_ff;
      pend_in   = pend_ff;
      if (fire) begin
         phase_in = ph;
         hpos_in  = pos;
         ok_in    = ok;
         await_in = await;
         pend_in  = pend;
         unique case (ph)
            PH_HEADER: begin
               if (mismatch) ok_in = 1'b0;
               if (pos == HDR_POS_XMAX_LO || pos == HDR_POS_YMAX_LO ||
                   pos == HDR_POS_BPL_LO) low_in = in_byte;
               if (pos == HDR_POS_XMAX_HI) lcol_in = {in_byte, low_ff};
               if (pos == HDR_POS_YMAX_HI) lline_in = {in_byte, low_ff};
               if (pos == HDR_POS_PLANES) planes_in = in_byte;
               if (pos == HDR_POS_BPL_HI) bpr_in = {in_byte, low_ff};
               if (pos == HDR_POS_LAST) begin
                  hpos_in  = 7'd0;
                  phase_in = ok ? PH_PIXELS : PH_REJECT;
                  await_in = 1'b0;
                  pend_in  = 6'd0;
               end else begin
                  hpos_in = pos + 7'd1;
               end
            end
            PH_PIXELS: begin
               if (await) begin
                  await_in = 1'b0;
               end else if (run_byte) begin
                  await_in = 1'b1;
                  pend_in  = 6'(in_byte & RUN_MASK);
               end
            end
            PH_REJECT: ;
            default: ;
         endcase
      end
   end

   // outputs
   assign span  = 24'(planes_ff) * 24'(bpr_ff);
   assign width = {1'b0, lcol_ff} + 17'd1;

   always_comb begin
      q_push          = 1'b0;
      q_cmd.kind      = CMD_PIXELS;
      q_cmd.value     = in_byte;
      q_cmd.count     = await ? pend : 6'd1;
      q_cmd.last_col  = lcol_ff;
      q_cmd.last_line = lline_ff;
      q_cmd.row_len   = (span > 24'(width)) ? span : 24'(width);
      unique case (ph)
         PH_HEADER: begin
            q_cmd.kind = ok ? CMD_HDR_OK : CMD_HDR_BAD;
            q_push     = fire && (pos == HDR_POS_LAST);
         end
         PH_PIXELS: q_push = fire && (await || !run_byte);
         PH_REJECT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hpos_ff   <= 7'd0;
         ok_ff     <= 1'b1;
         low_ff    <= 8'd0;
         lcol_ff   <= 16'd0;
         lline_ff  <= 16'd0;
         planes_ff <= 8'd0;
         bpr_ff    <= 16'd0;
         await_ff  <= 1'b0;
         pend_ff   <= 6'd0;
      end else begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         ok_ff     <= ok_in;
         low_ff    <= low_in;
         lcol_ff   <= lcol_in;
         lline_ff  <= lline_in;
         planes_ff <= planes_in;
         bpr_ff    <= bpr_in;
         await_ff  <= await_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

[rtl/core/pcxrle_cmd_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on pcxrle_pkg for the command type.
module pcxrle_cmd_fifo #(
   parameter int DEPTH = pcxrle_pkg::CMD_FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcxrle_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output pcxrle_pkg::cmd_type head,
   output logic                empty
);
   import pcxrle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full    = cnt_ff == CNT_W'(DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/core/pcxrle_back.sv]
// Back end: expands queued commands into pixel and header results.
// Depends on pcxrle_pkg; owns the row position and the output register.
module pcxrle_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  pcxrle_pkg::cmd_type       head,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [79:0]               rsp_tdata,
   output logic [2:0]                rsp_tuser,
   output logic                      rsp_tlast,
   output pcxrle_pkg::back_stat_type stat
);
   import pcxrle_pkg::*;

   logic [23:0] pos_ff, pos_in;
   logic [15:0] row_ff, row_in;
   logic        done_ff, done_in;
   logic        started_ff, started_in;
   logic [5:0]  rem_ff, rem_in;
   logic [15:0] lcol_ff, lcol_in;
   logic [15:0] lline_ff, lline_in;
   logic [23:0] rlen_ff, rlen_in;

   logic        ovalid_ff, ovalid_in;
   logic [1:0]  okind_ff, okind_in;
   logic [7:0]  opix_ff, opix_in;
   logic [15:0] ocol_ff, ocol_in;
   logic [15:0] oline_ff, oline_in;
   logic [16:0] ow_ff, ow_in;
   logic [16:0] oh_ff, oh_in;
   logic        olast_ff, olast_in;
   logic        odone_ff, odone_in;

   logic        out_free;
   logic [5:0]  r;
   logic [16:0] width;
   logic        in_img;
   logic [23:0] pos_inc;
   logic        wrap_step;
   logic [24:0] pad_sum;
   logic        wrap_pad;
   logic        at_last_col;

   assign out_free    = !ovalid_ff || rsp_tready;
   assign r           = started_ff ? rem_ff : head.count;
   assign width       = {1'b0, lcol_ff} + 17'd1;
   assign in_img      = pos_ff < 24'(width);
   assign pos_inc     = pos_ff + 24'd1;
   assign wrap_step   = pos_inc >= rlen_ff;
   assign pad_sum     = {1'b0, pos_ff} + 25'(r);
   assign wrap_pad    = pad_sum >= {1'b0, rlen_ff};
   assign at_last_col = pos_ff == {8'd0, lcol_ff};

   always_comb begin
      q_pop      = 1'b0;
      pos_in     = pos_ff;
      row_in     = row_ff;
      done_in    = done_ff;
      started_in = started_ff;
      rem_in     = rem_ff;
      lcol_in    = lcol_ff;
      lline_in   = lline_ff;
      rlen_in    = rlen_ff;
      ovalid_in  = ovalid_ff && !rsp_tready;
      okind_in   = okind_ff;
      opix_in    = opix_ff;
      ocol_in    = ocol_ff;
      oline_in   = oline_ff;
      ow_in      = ow_ff;
      oh_in      = oh_ff;
      olast_in   = olast_ff;
      odone_in   = odone_ff;
      if (q_valid) begin
         unique case (head.kind)
            CMD_HDR_OK: begin
               if (out_free) begin
                  q_pop      = 1'b1;
                  ovalid_in  = 1'b1;
                  okind_in   = RES_ACCEPT;
                  opix_in    = 8'd0;
                  ocol_in    = 16'd0;
                  oline_in   = 16'd0;
                  ow_in      = {1'b0, head.last_col} + 17'd1;
                  oh_in      = {1'b0, head.last_line} + 17'd1;
                  olast_in   = 1'b1;
                  odone_in   = 1'b0;
                  lcol_in    = head.last_col;
                  lline_in   = head.last_line;
                  rlen_in    = head.row_len;
                  pos_in     = 24'd0;
                  row_in     = 16'd0;
                  done_in    = 1'b0;
                  started_in = 1'b0;
               end
            end
            CMD_HDR_BAD: begin
               if (out_free) begin
                  q_pop     = 1'b1;
                  ovalid_in = 1'b1;
                  okind_in  = RES_REJECT;
                  opix_in   = 8'd0;
                  ocol_in   = 16'd0;
                  oline_in  = 16'd0;
                  ow_in     = 17'd0;
                  oh_in     = 17'd0;
                  olast_in  = 1'b1;
                  odone_in  = 1'b0;
               end
            end
            CMD_PIXELS: begin
               if (done_ff || r == 6'd0) begin
                  q_pop      = 1'b1;
                  started_in = 1'b0;
               end else if (in_img) begin
                  if (out_free) begin
                     ovalid_in = 1'b1;
                     okind_in  = RES_PIXEL;
                     opix_in   = head.value;
                     ocol_in   = pos_ff[15:0];
                     oline_in  = row_ff;
                     ow_in     = 17'd0;
                     oh_in     = 17'd0;
                     olast_in  = (r == 6'd1) || at_last_col;
                     odone_in  = at_last_col && (row_ff == lline_ff);
                     if (wrap_step) begin
                        q_pop      = 1'b1;
                        started_in = 1'b0;
                        pos_in     = 24'd0;
                        row_in     = row_ff + 16'd1;
                        if (row_ff >= lline_ff) done_in = 1'b1;
                     end else if (r == 6'd1) begin
                        q_pop      = 1'b1;
                        started_in = 1'b0;
                        pos_in     = pos_inc;
                     end else begin
                        started_in = 1'b1;
                        rem_in     = r - 6'd1;
                        pos_in     = pos_inc;
                     end
                  end
               end else begin
                  // padding columns: skip the rest of the run at once
                  q_pop      = 1'b1;
                  started_in = 1'b0;
                  if (wrap_pad) begin
                     pos_in = 24'd0;
                     row_in = row_ff + 16'd1;
                     if (row_ff >= lline_ff) done_in = 1'b1;
                  end else begin
                     pos_in = pad_sum[23:0];
                  end
               end
            end
            default: q_pop = 1'b1;
         endcase
      end
   end

   assign rsp_tvalid   = ovalid_ff;
   assign rsp_tdata    = {6'd0, oh_ff, ow_ff, oline_ff, ocol_ff, opix_ff};
   assign rsp_tuser    = {odone_ff, okind_ff};
   assign rsp_tlast    = olast_ff;
   assign stat.started = started_ff;
   assign stat.done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff  <= 1'b0;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
         pos_ff     <= 24'd0;
         row_ff     <= 16'd0;
      end else begin
         ovalid_ff  <= ovalid_in;
         started_ff <= started_in;
         done_ff    <= done_in;
         pos_ff     <= pos_in;
         row_ff     <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      lcol_ff  <= lcol_in;
      lline_ff <= lline_in;
      rlen_ff  <= rlen_in;
      okind_ff <= okind_in;
      opix_ff  <= opix_in;
      ocol_ff  <= ocol_in;
      oline_ff <= oline_in;
      ow_ff    <= ow_in;
      oh_ff    <= oh_in;
      olast_ff <= olast_in;
      odone_ff <= odone_in;
   end

endmodule

[rtl/core/pcx_rle_image_decoder_unit.sv]
// PCX 8 bpp run-length image decoder, top level.
// Depends on pcxrle_pkg, pcxrle_front, pcxrle_cmd_fifo, pcxrle_back and the assert header.
//
// Usage:
//   req channel takes one file byte per transfer; tuser marks the first byte of a
//   new file and restarts header parsing. The 128 header bytes give one result
//   (accept with width/height, or reject); later bytes give pixels with column/line.
//   rsp channel carries one result per transfer; tlast marks the last result of
//   an input byte, tuser holds the kind and the image-done flag.
// Path: a byte's first result is registered in a queue entry, then in the output
//   register, before it can transfer.
// Throughput: one byte per cycle for header and literal pixel bytes while the queue
//   has room. A run's visible pixels leave the back end's output register one at a
//   time; columns past the width are skipped at once. The 4-entry command queue lets
//   the front keep taking bytes during a run until it fills, then req_tready drops.
// Reset: synchronous; the queue and output register empty, parsing starts at
//   header byte 0. When rsp_tready is low the result holds and the queue fills.
module pcx_rle_image_decoder_unit #(
   parameter int FIFO_DEPTH = pcxrle_pkg::CMD_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] file_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] pixel_value, [23:8] column, [39:24] line,
                                    // [56:40] image_width, [73:57] image_height
   output logic [2:0]  rsp_tuser,   // [1:0] result_kind, [2] image_done
   output logic        rsp_tlast    // last_of_run
);
   import pcxrle_pkg::*;

`include "pcx_rle_image_decoder_unit_assert.svh"

   cmd_type       push_cmd;
   cmd_type       q_head;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   back_stat_type bstat;

   pcxrle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_byte  (req_tdata),
      .in_start (req_tuser),
      .in_ready (req_tready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   pcxrle_cmd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   pcxrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_empty),
      .head       (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .stat       (bstat)
   );

   `PCXRLE_ASSERT_IMP(a_hdr_is_last, rsp_tvalid && rsp_tuser[1:0] != RES_PIXEL, rsp_tlast)
   `PCXRLE_ASSERT_IMP(a_done_is_last, rsp_tvalid && rsp_tuser[2], rsp_tlast)
   `PCXRLE_ASSERT_NEVER(a_run_head, bstat.started && (q_empty || q_head.kind != CMD_PIXELS))

endmodule
